/* rtl/mahal_pkg.sv */
// Shared constants, types and fixed-point helpers for the Mahalanobis outlier detector.
// Depends on nothing; imported by the core, the divider and the checker.
package mahal_pkg;

  localparam int DIM          = 8;
  localparam int MAX_SAMPLES  = 64;
  localparam int STORE_DEPTH  = MAX_SAMPLES * DIM;
  localparam int CNT_W        = $clog2(STORE_DEPTH + 1);
  localparam int SADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W        = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int COL_W        = IDX_W + 1;
  localparam int AUG_ADDR_W   = IDX_W + COL_W;
  localparam int SIDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NCNT_W       = SIDX_W + 1;
  localparam int FC_W         = 4;
  localparam int WORD_W       = 32;
  localparam int WIDE_W       = 64;
  localparam int VAL_W        = 16;

  localparam logic [WORD_W-1:0] THRESHOLD_RESET = 32'd196608;
  localparam logic [FC_W-1:0]   FC_RESET        = 4'd4;
  localparam logic [WORD_W-1:0] Q_ONE           = 32'd65536;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE_COUNT = 1'd1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_TOO_FEW = 2'd1,
    STATUS_NOT_PD  = 2'd2
  } status_t;

  // Saturate a wide signed value into signed 32 bits.
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sh0000_0000_7FFF_FFFF);
    lo = WIDE_W'(-64'sh0000_0000_8000_0000);
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = -32'sh8000_0000;
    end else begin
      sat32 = v[WORD_W-1:0];
    end
  endfunction

  // Divide by 65536 with truncation toward zero.
  function automatic logic signed [WIDE_W-1:0] trunc16(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] bias;
    bias = v[WIDE_W-1] ? WIDE_W'(64'sd65535) : '0;
    trunc16 = (v + bias) >>> 16;
  endfunction

endpackage

/* rtl/mahal_div.sv */
// Restoring divider, one quotient bit per cycle, signed dividend and positive divisor.
// Depends on mahal_pkg for widths.
module mahal_div import mahal_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [WIDE_W-1:0] dividend,
  input  logic        [WORD_W-1:0] divisor,
  output logic                     done,
  output logic signed [WIDE_W-1:0] quotient
);

  localparam int STEP_W = $clog2(WIDE_W);

  logic              busy_r;
  logic              done_r;
  logic              neg_r;
  logic [STEP_W-1:0] step_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] dvs_r;
  logic [WIDE_W-1:0] q_r;

  logic [WORD_W:0]   rem_sh;
  logic              ge;
  logic [WORD_W:0]   rem_sub;
  logic [WORD_W-1:0] rem_nxt;

  always_comb begin
    rem_sh  = {rem_r, q_r[WIDE_W-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
    rem_nxt = ge ? rem_sub[WORD_W-1:0] : rem_sh[WORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        neg_r  <= dividend[WIDE_W-1];
        q_r    <= dividend[WIDE_W-1] ? WIDE_W'(-dividend) : WIDE_W'(dividend);
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        q_r    <= {q_r[WIDE_W-2:0], ge};
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(WIDE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

/* rtl/mahalanobis_outlier_detector_core.sv */
// Top level of the Mahalanobis outlier detector: sample store, matrix memory and sequencer.
// Depends on mahal_pkg and instantiates the shared divider mahal_div.
//
//   Channel  Direction  Handshake          Carries
//   in_      input      valid / stall      feature_value, last
//   out_     output     valid / stall      sample_index, distance, is_outlier, status,
//                                          end_of_run
//   cfg_     input      valid / ready      index, data (threshold, feature_count)
//
// While a set is loading the block takes one item per cycle and writes it into the
// sample store. The item that carries last starts the computation, and in_stall stays
// high until the final result of the set has been placed in the output register. The
// work runs on 32x32 multiplies and one bit-per-cycle divider: it first finds n by taking
// d from the item count repeatedly, then works out the mean, the covariance, the
// inversion and the distances, in that order.
// Reset is synchronous; it clears the control state and loads the register defaults.
// The stores need no clearing pass, since every entry read in a set is written in it.
// A stall on the result channel holds the sequencer at its emit step.
module mahalanobis_outlier_detector_core import mahal_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [VAL_W-1:0]     in_feature_value,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [SIDX_W-1:0]           out_sample_index,
  output logic [WORD_W-1:0]           out_distance,
  output logic                        out_is_outlier,
  output logic [1:0]                  out_status,
  output logic                        out_end_of_run,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [WORD_W-1:0]           cfg_data
);

  typedef enum logic [5:0] {
    S_LOAD, S_COUNT,
    S_M_RD, S_M_ACC, S_M_DIV, S_M_WAIT,
    S_C_RA, S_C_WA, S_C_RB, S_C_WB, S_C_MUL, S_C_ACC, S_C_DIV, S_C_WAIT, S_C_ID,
    S_G_RP, S_G_WP, S_G_NR, S_G_NW, S_G_NWAIT,
    S_G_RF, S_G_WF, S_G_RK, S_G_WK, S_G_RI, S_G_WI,
    S_D_LR, S_D_LW, S_D_RM, S_D_MUL, S_D_ACC, S_D_Y, S_D_YM, S_D_T, S_D_FIN, S_D_EMIT,
    S_STAT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [WORD_W-1:0] thr_r;
  logic [FC_W-1:0]   fc_r;

  // Loop counters and set geometry.
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  ncnt_r;
  logic [FC_W-1:0]   d_r;
  logic [IDX_W-1:0]  d_m1_r;
  logic [SIDX_W-1:0] n_m1_r;
  logic [SIDX_W-1:0] s_r;
  logic [IDX_W-1:0]  i_r;
  logic [IDX_W-1:0]  k_r;
  logic [COL_W-1:0]  j_r;

  // Datapath registers.
  logic signed [WIDE_W-1:0] acc_r;
  logic signed [WIDE_W-1:0] tot_r;
  logic signed [WIDE_W-1:0] prod_r;
  logic signed [WORD_W-1:0] da_r;
  logic signed [WORD_W-1:0] db_r;
  logic signed [WORD_W-1:0] f_r;
  logic signed [WORD_W-1:0] piv_r;
  logic signed [WORD_W-1:0] y_r;
  logic        [WORD_W-1:0] dist_r;
  status_t                  st_r;
  logic signed [WORD_W-1:0] mean_r [DIM];
  logic signed [WORD_W-1:0] dvec_r [DIM];

  // Output register.
  logic              out_valid_r;
  logic [SIDX_W-1:0] out_idx_r;
  logic [WORD_W-1:0] out_dist_r;
  logic              out_outl_r;
  status_t           out_st_r;
  logic              out_eor_r;

  // Memories.
  logic signed [VAL_W-1:0]  store_mem [STORE_DEPTH];
  logic signed [VAL_W-1:0]  store_rd_r;
  logic signed [WORD_W-1:0] aug_mem [DIM * 2 * DIM];
  logic signed [WORD_W-1:0] aug_rd_r;

  // Combinational control.
  logic                     in_acc;
  logic                     store_we;
  logic [SADDR_W-1:0]       store_raddr;
  logic [IDX_W-1:0]         fsel;
  logic [CNT_W-1:0]         sd_prod;
  logic [CNT_W-1:0]         saddr_full;
  logic                     aug_we;
  logic [AUG_ADDR_W-1:0]    aug_waddr;
  logic [AUG_ADDR_W-1:0]    aug_raddr;
  logic signed [WORD_W-1:0] aug_wdata;
  logic [COL_W-1:0]         col_dj;
  logic [COL_W-1:0]         col_last;
  logic [IDX_W-1:0]         j_lo;
  logic [IDX_W-1:0]         msel;
  logic [IDX_W-1:0]         dsel;
  logic signed [WORD_W-1:0] mean_sel;
  logic signed [WORD_W-1:0] dvec_sel;
  logic signed [WORD_W-1:0] x_diff;
  logic signed [WORD_W-1:0] elim_val;
  logic signed [WIDE_W-1:0] tot_t;
  logic [FC_W-1:0]          d_clamp;
  logic [NCNT_W-1:0]        n_clamp;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     out_free;

  logic                     div_start;
  logic signed [WIDE_W-1:0] div_dividend;
  logic [WORD_W-1:0]        div_divisor;
  logic                     div_done;
  logic signed [WIDE_W-1:0] div_q;

  mahal_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  // A feature count of zero is taken as one, and one above DIM as DIM.
  always_comb begin
    if (fc_r == '0) begin
      d_clamp = FC_W'(1);
    end else if (fc_r > FC_W'(DIM)) begin
      d_clamp = FC_W'(DIM);
    end else begin
      d_clamp = fc_r;
    end
    n_clamp = (ncnt_r > CNT_W'(MAX_SAMPLES)) ? NCNT_W'(MAX_SAMPLES) : ncnt_r[NCNT_W-1:0];
    cnt_inc = (cnt_r < CNT_W'(STORE_DEPTH)) ? cnt_r + 1'b1 : cnt_r;
  end

  assign store_we = in_acc && (cnt_r < CNT_W'(STORE_DEPTH));

  // Sample store address: sample times feature count plus feature.
  always_comb begin
    j_lo        = j_r[IDX_W-1:0];
    fsel        = (state_r == S_C_RA) ? i_r : j_lo;
    sd_prod     = CNT_W'(s_r) * CNT_W'(d_r);
    saddr_full  = sd_prod + CNT_W'(fsel);
    store_raddr = saddr_full[SADDR_W-1:0];
    msel        = (state_r == S_C_WA) ? i_r : j_lo;
    dsel        = (state_r == S_D_YM) ? i_r : j_lo;
    mean_sel    = mean_r[msel];
    dvec_sel    = dvec_r[dsel];
    x_diff      = (WORD_W'(store_rd_r) <<< 8) - mean_sel;
    col_dj      = d_r + COL_W'(j_lo);
    col_last    = {d_m1_r, 1'b1};
    elim_val    = sat32(WIDE_W'(aug_rd_r) - trunc16(prod_r));
    tot_t       = trunc16(tot_r);
  end

  // Matrix memory ports and divider operands, all chosen by the sequencer state.
  always_comb begin
    aug_we       = 1'b0;
    aug_waddr    = '0;
    aug_wdata    = '0;
    aug_raddr    = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_r)
      S_M_DIV: begin
        div_start    = 1'b1;
        div_dividend = acc_r <<< 8;
        div_divisor  = WORD_W'(n_m1_r) + 1'b1;
      end
      S_C_DIV: begin
        div_start    = 1'b1;
        div_dividend = acc_r;
        div_divisor  = WORD_W'(n_m1_r) << 16;
      end
      S_C_WAIT: begin
        aug_we    = div_done;
        aug_waddr = {i_r, 1'b0, j_lo};
        aug_wdata = sat32(div_q);
      end
      S_C_ID: begin
        aug_we    = 1'b1;
        aug_waddr = {i_r, col_dj};
        aug_wdata = (i_r == j_lo) ? $signed(Q_ONE) : '0;
      end
      S_G_RP:  aug_raddr = {k_r, 1'b0, k_r};
      S_G_NR:  aug_raddr = {k_r, j_r};
      S_G_NW: begin
        div_start    = 1'b1;
        div_dividend = WIDE_W'(aug_rd_r) <<< 16;
        div_divisor  = WORD_W'(piv_r);
      end
      S_G_NWAIT: begin
        aug_we    = div_done;
        aug_waddr = {k_r, j_r};
        aug_wdata = sat32(div_q);
      end
      S_G_RF:  aug_raddr = {i_r, 1'b0, k_r};
      S_G_RK:  aug_raddr = {k_r, j_r};
      S_G_RI:  aug_raddr = {i_r, j_r};
      S_G_WI: begin
        aug_we    = 1'b1;
        aug_waddr = {i_r, j_r};
        aug_wdata = elim_val;
      end
      S_D_RM:  aug_raddr = {i_r, col_dj};
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[cnt_r[SADDR_W-1:0]] <= in_feature_value;
    end
    store_rd_r <= store_mem[store_raddr];
  end

  always_ff @(posedge clk) begin
    if (aug_we) begin
      aug_mem[aug_waddr] <= aug_wdata;
    end
    aug_rd_r <= aug_mem[aug_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      thr_r       <= THRESHOLD_RESET;
      fc_r        <= FC_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THRESHOLD:     thr_r <= cfg_data;
          REG_FEATURE_COUNT: fc_r  <= cfg_data[FC_W-1:0];
          default: begin
          end
        endcase
      end

      // The emit states refill the output register themselves.
      if (out_valid_r && !out_stall && (state_r != S_D_EMIT) && (state_r != S_STAT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (in_last) begin
              // The set is closed: the count restarts and the sample count is found.
              cnt_r   <= '0;
              rem_r   <= cnt_inc;
              ncnt_r  <= '0;
              d_r     <= d_clamp;
              d_m1_r  <= IDX_W'(d_clamp - 1'b1);
              state_r <= S_COUNT;
            end else begin
              cnt_r <= cnt_inc;
            end
          end
        end

        S_COUNT: begin
          if (rem_r >= CNT_W'(d_r)) begin
            rem_r  <= rem_r - CNT_W'(d_r);
            ncnt_r <= ncnt_r + 1'b1;
          end else begin
            n_m1_r <= SIDX_W'(n_clamp - 1'b1);
            s_r    <= '0;
            j_r    <= '0;
            acc_r  <= '0;
            if (n_clamp <= NCNT_W'(d_r)) begin
              st_r    <= STATUS_TOO_FEW;
              state_r <= S_STAT;
            end else begin
              state_r <= S_M_RD;
            end
          end
        end

        // Mean of each feature.
        S_M_RD:  state_r <= S_M_ACC;
        S_M_ACC: begin
          acc_r <= acc_r + WIDE_W'(store_rd_r);
          if (s_r == n_m1_r) begin
            state_r <= S_M_DIV;
          end else begin
            s_r     <= s_r + 1'b1;
            state_r <= S_M_RD;
          end
        end
        S_M_DIV: state_r <= S_M_WAIT;
        S_M_WAIT: begin
          if (div_done) begin
            mean_r[j_lo] <= sat32(div_q);
            s_r          <= '0;
            acc_r        <= '0;
            if (j_lo == d_m1_r) begin
              i_r     <= '0;
              j_r     <= '0;
              state_r <= S_C_RA;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_M_RD;
            end
          end
        end

        // Covariance entry (i, j) and the identity half of the augmented matrix.
        S_C_RA:  state_r <= S_C_WA;
        S_C_WA: begin
          da_r    <= x_diff;
          state_r <= S_C_RB;
        end
        S_C_RB:  state_r <= S_C_WB;
        S_C_WB: begin
          db_r    <= x_diff;
          state_r <= S_C_MUL;
        end
        S_C_MUL: begin
          prod_r  <= WIDE_W'(da_r) * WIDE_W'(db_r);
          state_r <= S_C_ACC;
        end
        S_C_ACC: begin
          acc_r <= acc_r + prod_r;
          if (s_r == n_m1_r) begin
            state_r <= S_C_DIV;
          end else begin
            s_r     <= s_r + 1'b1;
            state_r <= S_C_RA;
          end
        end
        S_C_DIV:  state_r <= S_C_WAIT;
        S_C_WAIT: begin
          if (div_done) begin
            state_r <= S_C_ID;
          end
        end
        S_C_ID: begin
          s_r   <= '0;
          acc_r <= '0;
          if (j_lo == d_m1_r) begin
            j_r <= '0;
            if (i_r == d_m1_r) begin
              k_r     <= '0;
              state_r <= S_G_RP;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_C_RA;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_C_RA;
          end
        end

        // Gauss-Jordan elimination, pivot row k.
        S_G_RP:  state_r <= S_G_WP;
        S_G_WP: begin
          if (aug_rd_r <= 0) begin
            st_r    <= STATUS_NOT_PD;
            state_r <= S_STAT;
          end else begin
            piv_r   <= aug_rd_r;
            j_r     <= '0;
            state_r <= S_G_NR;
          end
        end
        S_G_NR:  state_r <= S_G_NW;
        S_G_NW:  state_r <= S_G_NWAIT;
        S_G_NWAIT: begin
          if (div_done) begin
            if (j_r == col_last) begin
              i_r     <= '0;
              state_r <= S_G_RF;
            end else begin
              j_r     <= j_r + 1'b1;
              state_r <= S_G_NR;
            end
          end
        end
        S_G_RF: begin
          if (i_r == k_r) begin
            if (i_r == d_m1_r) begin
              if (k_r == d_m1_r) begin
                s_r     <= '0;
                j_r     <= '0;
                state_r <= S_D_LR;
              end else begin
                k_r     <= k_r + 1'b1;
                state_r <= S_G_RP;
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            state_r <= S_G_WF;
          end
        end
        S_G_WF: begin
          f_r     <= aug_rd_r;
          j_r     <= '0;
          state_r <= S_G_RK;
        end
        S_G_RK:  state_r <= S_G_WK;
        S_G_WK: begin
          prod_r  <= WIDE_W'(f_r) * WIDE_W'(aug_rd_r);
          state_r <= S_G_RI;
        end
        S_G_RI:  state_r <= S_G_WI;
        S_G_WI: begin
          if (j_r == col_last) begin
            if (i_r == d_m1_r) begin
              if (k_r == d_m1_r) begin
                s_r     <= '0;
                j_r     <= '0;
                state_r <= S_D_LR;
              end else begin
                k_r     <= k_r + 1'b1;
                state_r <= S_G_RP;
              end
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_G_RF;
            end
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_G_RK;
          end
        end

        // Distance of sample s: gather its centred features, then the quadratic form.
        S_D_LR:  state_r <= S_D_LW;
        S_D_LW: begin
          dvec_r[j_lo] <= x_diff;
          if (j_lo == d_m1_r) begin
            i_r     <= '0;
            j_r     <= '0;
            acc_r   <= '0;
            tot_r   <= '0;
            state_r <= S_D_RM;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_D_LR;
          end
        end
        S_D_RM:  state_r <= S_D_MUL;
        S_D_MUL: begin
          prod_r  <= WIDE_W'(aug_rd_r) * WIDE_W'(dvec_sel);
          state_r <= S_D_ACC;
        end
        S_D_ACC: begin
          acc_r <= acc_r + prod_r;
          if (j_lo == d_m1_r) begin
            state_r <= S_D_Y;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= S_D_RM;
          end
        end
        S_D_Y: begin
          y_r     <= sat32(trunc16(acc_r));
          state_r <= S_D_YM;
        end
        S_D_YM: begin
          prod_r  <= WIDE_W'(dvec_sel) * WIDE_W'(y_r);
          state_r <= S_D_T;
        end
        S_D_T: begin
          tot_r <= tot_r + prod_r;
          if (i_r == d_m1_r) begin
            state_r <= S_D_FIN;
          end else begin
            i_r     <= i_r + 1'b1;
            j_r     <= '0;
            acc_r   <= '0;
            state_r <= S_D_RM;
          end
        end
        S_D_FIN: begin
          if (tot_t < 0) begin
            dist_r <= '0;
          end else if (tot_t > WIDE_W'(64'sh0000_0000_FFFF_FFFF)) begin
            dist_r <= '1;
          end else begin
            dist_r <= tot_t[WORD_W-1:0];
          end
          state_r <= S_D_EMIT;
        end
        S_D_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= s_r;
            out_dist_r  <= dist_r;
            out_outl_r  <= (dist_r >= thr_r);
            out_st_r    <= STATUS_OK;
            out_eor_r   <= (s_r == n_m1_r);
            j_r         <= '0;
            if (s_r == n_m1_r) begin
              state_r <= S_LOAD;
            end else begin
              s_r     <= s_r + 1'b1;
              state_r <= S_D_LR;
            end
          end
        end

        // Status-only result that ends the set.
        S_STAT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= '0;
            out_dist_r  <= '0;
            out_outl_r  <= 1'b0;
            out_st_r    <= st_r;
            out_eor_r   <= 1'b1;
            state_r     <= S_LOAD;
          end
        end

        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_index = out_idx_r;
  assign out_distance     = out_dist_r;
  assign out_is_outlier   = out_outl_r;
  assign out_status       = out_st_r;
  assign out_end_of_run   = out_eor_r;

endmodule

/* rtl/mahal_chk.sv */
// Port-level checker for the Mahalanobis outlier detector, bound to the core.
// Depends on mahal_pkg and on the port list of mahalanobis_outlier_detector_core.
module mahal_chk import mahal_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    in_last,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SIDX_W-1:0]       out_sample_index,
  input logic [WORD_W-1:0]       out_distance,
  input logic                    out_is_outlier,
  input logic [1:0]              out_status,
  input logic                    out_end_of_run
);

  // Closing a set makes the block busy at once.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last |=> in_stall)
    else $error("input not stalled after the closing item");

  // A new result only appears after computation with input stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised while the block was loading");

  // Status results carry nothing but the status and close the set.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STATUS_OK) |->
      out_end_of_run && (out_distance == '0) && !out_is_outlier && (out_sample_index == '0))
    else $error("malformed status result");

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_distance)
      && $stable(out_sample_index) && $stable(out_end_of_run))
    else $error("stalled result changed");

endmodule

bind mahalanobis_outlier_detector_core mahal_chk u_mahal_chk (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for mahalanobis_outlier_detector_core: directed sets from a table,
// then random sets, all checked against a fixed-point Mahalanobis predictor in this file.
// Depends on mahal_pkg and the core RTL only.
module testbench;
  import mahal_pkg::*;

  // Each result item as the block presents it on the out_ channel.
  typedef struct packed {
    logic [SIDX_W-1:0] sample_index;
    logic [WORD_W-1:0] distance;
    logic              is_outlier;
    logic [1:0]        status;
    logic              end_of_run;
  } verdict_t;

  // Shapes of value sequence used when a set is generated.
  typedef enum int {PAT_RAMP, PAT_CONST, PAT_ALT, PAT_RAND} pattern_t;

  // One directed set: the registers it runs under, how many items it carries and their
  // shape. Where the outcome is obvious it is typed in; otherwise the predictor decides.
  typedef struct {
    logic [FC_W-1:0]   fc;
    logic [WORD_W-1:0] thr;
    int                nvals;
    pattern_t          pat;
    bit                typed;
    status_t           st;
  } set_row_t;

  localparam int IDLE_LIMIT  = 300000;
  localparam int DRAIN_WAIT  = 200;
  localparam int SETTLE_WAIT = 40;
  localparam int RAND_ITEMS  = 290;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_feature_value;
  logic                    in_last;
  logic                    out_valid;
  logic                    out_stall;
  logic [SIDX_W-1:0]       out_sample_index;
  logic [WORD_W-1:0]       out_distance;
  logic                    out_is_outlier;
  logic [1:0]              out_status;
  logic                    out_end_of_run;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [WORD_W-1:0]       cfg_data;

  mahalanobis_outlier_detector_core u_top (.*);

  // Mirror of the block's state, kept by the predictor.
  shortint           mirror_store [STORE_DEPTH];
  int                mirror_count;
  logic [WORD_W-1:0] mirror_thr;
  logic [FC_W-1:0]   mirror_fc;

  verdict_t pending_verdicts[$];
  int       mismatches  = 0;
  int       idle_cycles = 0;
  bit       timed_out   = 1'b0;
  int       burst_left;

  // The clock runs freely for the whole of the simulation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return -32'sh8000_0000;
    return int'(v);
  endfunction

  // Appends one expected result item to the back of the queue.
  function automatic void expect_verdict(input verdict_t v);
    pending_verdicts.insert(pending_verdicts.size(), v);
  endfunction

  // Works out every result item of a completed set from the mirrored store, in the
  // same order of operations and the same truncating Q16.16 steps as the block.
  task automatic predict_distances();
    int     d;
    int     n;
    int     mean [DIM];
    int     aug [DIM][2*DIM];
    longint sum;
    longint acc;
    longint piv;
    longint fac;
    longint total;
    longint dv [DIM];
    int     y;
    verdict_t v;
    d = (mirror_fc == 0) ? 1 : ((mirror_fc > DIM) ? DIM : int'(mirror_fc));
    n = mirror_count / d;
    if (n > MAX_SAMPLES) n = MAX_SAMPLES;
    if (n <= d) begin
      expect_verdict('{0, 0, 1'b0, STATUS_TOO_FEW, 1'b1});
      return;
    end
    for (int j = 0; j < d; j++) begin
      sum = 0;
      for (int s = 0; s < n; s++) sum += longint'(mirror_store[s*d + j]);
      mean[j] = clip32(sum * 256 / n);
    end
    for (int i = 0; i < d; i++) begin
      for (int j = 0; j < d; j++) begin
        acc = 0;
        for (int s = 0; s < n; s++)
          acc += (longint'(mirror_store[s*d + i]) * 256 - mean[i]) *
                 (longint'(mirror_store[s*d + j]) * 256 - mean[j]);
        aug[i][j]     = clip32(acc / (longint'(n - 1) * 65536));
        aug[i][d + j] = (i == j) ? 65536 : 0;
      end
    end
    // Gauss-Jordan without pivoting; the first non-positive pivot ends the set.
    for (int k = 0; k < d; k++) begin
      piv = aug[k][k];
      if (piv <= 0) begin
        expect_verdict('{0, 0, 1'b0, STATUS_NOT_PD, 1'b1});
        return;
      end
      for (int j = 0; j < 2*d; j++) aug[k][j] = clip32(longint'(aug[k][j]) * 65536 / piv);
      for (int i = 0; i < d; i++) begin
        if (i != k) begin
          fac = aug[i][k];
          for (int j = 0; j < 2*d; j++)
            aug[i][j] = clip32(longint'(aug[i][j]) - fac * longint'(aug[k][j]) / 65536);
        end
      end
    end
    for (int s = 0; s < n; s++) begin
      for (int j = 0; j < d; j++) dv[j] = longint'(mirror_store[s*d + j]) * 256 - mean[j];
      total = 0;
      for (int i = 0; i < d; i++) begin
        acc = 0;
        for (int j = 0; j < d; j++) acc += longint'(aug[i][d + j]) * dv[j];
        y = clip32(acc / 65536);
        total += dv[i] * longint'(y);
      end
      total /= 65536;
      v.sample_index = s[SIDX_W-1:0];
      if (total < 0) v.distance = '0;
      else if (total > 64'sd4294967295) v.distance = '1;
      else v.distance = total[WORD_W-1:0];
      v.is_outlier = (v.distance >= mirror_thr);
      v.status     = STATUS_OK;
      v.end_of_run = (s + 1 == n);
      expect_verdict(v);
    end
  endtask

  // Mirrors one accepted item; a last item closes the set and yields its results.
  task automatic absorb_item(input logic signed [VAL_W-1:0] val, input logic lst,
                             input bit keep);
    if (mirror_count < STORE_DEPTH) begin
      mirror_store[mirror_count] = val;
      mirror_count++;
    end
    if (!lst) return;
    // Typed sets carry their own expectation, so nothing is predicted for them.
    if (keep) predict_distances();
    mirror_count = 0;
  endtask

  // Offers one item and waits for it to be taken. The sender runs in bursts with random
  // gaps between them; valid stays high from one item to the next inside a burst.
  task automatic offer_item(input logic signed [VAL_W-1:0] val, input logic lst,
                            input bit keep);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid         = 1'b1;
    in_feature_value = val;
    in_last          = lst;
    do @(posedge clk); while (in_stall);
    absorb_item(val, lst, keep);
    @(negedge clk);
  endtask

  // Registers are written only once the block has gone quiet.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [WORD_W-1:0] data);
    in_valid = 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (SETTLE_WAIT) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_THRESHOLD) mirror_thr = data;
    else mirror_fc = data[FC_W-1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value(input pattern_t pat, input int i,
                                                         input int shift);
    case (pat)
      PAT_RAMP:  return VAL_W'(i * 389 - 1500);
      PAT_CONST: return VAL_W'(16'sh7FFF);
      PAT_ALT:   return (i % 2 == 0) ? 16'sh7FFF : -16'sh8000;
      default:   return VAL_W'($signed(VAL_W'($urandom)) >>> shift);
    endcase
  endfunction

  // Sends a whole set, rewriting the registers first where they differ from the mirror.
  task automatic send_set(input logic [FC_W-1:0] fc, input logic [WORD_W-1:0] thr,
                          input int nvals, input pattern_t pat, input bit keep);
    int shift;
    if (fc != mirror_fc) write_register(REG_FEATURE_COUNT, WORD_W'(fc));
    if (thr != mirror_thr) write_register(REG_THRESHOLD, thr);
    shift = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 9);
    for (int i = 0; i < nvals; i++) offer_item(pick_value(pat, i, shift), i == nvals - 1, keep);
  endtask

  // The receiver stalls in modes picked at random each time the stall tick wraps: never, seldom,
  // mostly and a solid block, so that stalls land on every phase of the result stream.
  int  stall_mode = 0;
  int  stall_tick = 0;
  always @(negedge clk) begin
    if (stall_tick == 0) stall_mode <= $urandom_range(0, 3);
    stall_tick <= (stall_tick + 1) % 64;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick < 40);
    endcase
  end

  // Each result taken is checked against the oldest expectation, field by field.
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_sample_index, out_distance, out_is_outlier, out_status, out_end_of_run};
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item: %p", got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // The watchdog counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Some tests failed");
      $finish;
    end
  end

  // Directed sets: too few samples, zero covariance, alternating extremes that toggle
  // every bit, a partial trailing sample, and feature counts of zero and above DIM.
  set_row_t directed [6] = '{
    '{4'd4,  THRESHOLD_RESET, 4, PAT_CONST, 1'b1, STATUS_TOO_FEW},
    '{4'd1,  THRESHOLD_RESET, 2, PAT_CONST, 1'b1, STATUS_NOT_PD},
    '{4'd1,  32'd0,           3, PAT_ALT,   1'b0, STATUS_OK},
    '{4'd2,  32'hFFFF_FFFF,   7, PAT_RAMP,  1'b0, STATUS_OK},
    '{4'd0,  32'h0002_0000,   2, PAT_CONST, 1'b1, STATUS_NOT_PD},
    '{4'd15, 32'h0002_0000,   3, PAT_RAMP,  1'b1, STATUS_TOO_FEW}
  };

  initial begin
    int               sent;
    int               d;
    int               nvals;
    logic [FC_W-1:0]  fc;
    logic [WORD_W-1:0] thr;
    pattern_t         pat;
    burst_left       = 0;
    mirror_count     = 0;
    mirror_thr       = THRESHOLD_RESET;
    mirror_fc        = FC_RESET;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_feature_value = '0;
    in_last          = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_THRESHOLD;
    cfg_data         = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[r]) begin
      send_set(directed[r].fc, directed[r].thr, directed[r].nvals, directed[r].pat,
               !directed[r].typed);
      if (directed[r].typed)
        expect_verdict('{0, 0, 1'b0, directed[r].st, 1'b1});
    end

    // Random sets, mostly well formed with a few spare values; some are too short,
    // some constant, and now and then the feature count is set out of range.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      fc  = mirror_fc;
      thr = mirror_thr;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 9))
          0:       fc = 4'd0;
          1:       fc = FC_W'($urandom_range(9, 15));
          2, 3:    fc = FC_W'($urandom_range(5, 8));
          default: fc = FC_W'($urandom_range(1, 4));
        endcase
      end
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 4))
          0:       thr = 32'd0;
          1:       thr = 32'hFFFF_FFFF;
          2:       thr = $urandom;
          default: thr = $urandom_range(0, 32'h0010_0000);
        endcase
      end
      d = (fc == 0) ? 1 : ((fc > DIM) ? DIM : int'(fc));
      case ($urandom_range(0, 9))
        0:       nvals = $urandom_range(1, d * d);
        default: nvals = d * $urandom_range(d + 1, d + 6)
                         + $urandom_range(0, 1) * $urandom_range(0, d - 1);
      endcase
      pat = ($urandom_range(0, 11) == 0) ? PAT_CONST : PAT_RAND;
      if (nvals == 0) nvals = 1;
      send_set(fc, thr, nvals, pat, 1'b1);
      sent += nvals;
    end

    in_valid = 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
